// ===== rtl/core/tte_pkg.sv =====
// Shared constants, command struct and address helper for the text terminal cell engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package tte_pkg;

    localparam int ROWS   = 4;
    localparam int COLS   = 16;
    localparam int CELLS  = ROWS * COLS;
    localparam int WORDS  = (CELLS + 3) / 4;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLS + 1);   // cursor column can reach COLS
    localparam int DCOL_W = $clog2(COLS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int WORD_W = $clog2(WORDS);
    localparam int IDX_W  = WORD_W + 2;
    localparam int OFF_W  = 7;
    localparam int DATA_W = 32;

    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [OFF_W-1:0] STROBE_OFFSET = 7'd64;

    // register index on the config port (paddr[2])
    localparam logic REG_ENABLE = 1'b0;

    // work handed from the byte decoder to the sequencer
    typedef struct packed {
        logic              scroll;
        logic [ROW_W-1:0]  shift;   // source row distance for the copy pass
        logic              write;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_cmd;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0]  row,
                                                    input logic [DCOL_W-1:0] col);
        return ADDR_W'(ADDR_W'(row) * ADDR_W'(COLS)) + ADDR_W'(col);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tte_byte_dec.sv =====
// Byte decoder: escape parser, cursor and newline state; emits cell write / scroll commands.
// Depends on tte_pkg.
`default_nettype none

module tte_byte_dec
    import tte_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_byte,
    output t_cmd            o_cmd
);

    typedef enum logic [2:0] {
        P_TEXT, P_ESC, P_LBR, P_ROW, P_SEMI, P_COL
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic               r_pend, n_pend;
    logic [7:0]         r_rnum, n_rnum;
    logic [7:0]         r_cnum, n_cnum;

    logic               is_digit;
    logic [7:0]         acc_src;
    logic [11:0]        acc_x10;
    logic [7:0]         acc_sat;
    logic [8:0]         over;
    logic [ROW_W-1:0]   wr_row;
    logic [COL_W-1:0]   wr_col;

    assign is_digit = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign acc_src  = (r_phase == P_LBR || r_phase == P_ROW) ? r_rnum : r_cnum;
    assign acc_x10  = {4'b0, acc_src} * 12'd10 + {8'b0, i_byte[3:0]};
    assign acc_sat  = (acc_x10 > 12'd255) ? 8'hFF : acc_x10[7:0];
    assign over     = {1'b0, r_rnum} - 9'(ROWS - 1);

    always_comb begin
        n_phase = r_phase;
        n_row   = r_row;
        n_col   = r_col;
        n_pend  = r_pend;
        n_rnum  = r_rnum;
        n_cnum  = r_cnum;
        o_cmd   = '0;
        wr_row  = r_row;
        wr_col  = r_col;
        unique case (r_phase)
            P_TEXT: begin
                if (i_byte == CH_NL) begin
                    n_pend = 1'b1;
                end else if (i_byte == CH_ESC) begin
                    n_phase = P_ESC;
                end else begin
                    if (r_pend) begin
                        n_pend = 1'b0;
                        wr_col = '0;
                        if (r_row == ROW_W'(ROWS - 1)) begin
                            o_cmd.scroll = 1'b1;
                            o_cmd.shift  = ROW_W'(1);
                        end else begin
                            wr_row = r_row + 1'b1;
                        end
                    end
                    // a byte at the full-row column is dropped
                    if (wr_col < COL_W'(COLS)) begin
                        o_cmd.write = 1'b1;
                        o_cmd.addr  = cell_addr(wr_row, wr_col[DCOL_W-1:0]);
                        o_cmd.data  = i_byte;
                        wr_col      = wr_col + 1'b1;
                    end
                    n_row = wr_row;
                    n_col = wr_col;
                end
            end
            P_ESC: begin
                if (i_byte == CH_LBR) begin
                    n_rnum  = '0;
                    n_cnum  = '0;
                    n_phase = P_LBR;
                end else begin
                    n_phase = P_TEXT;
                end
            end
            P_LBR, P_ROW: begin
                if (is_digit) begin
                    n_rnum  = acc_sat;
                    n_phase = P_ROW;
                end else if (i_byte == CH_SEMI && r_phase == P_ROW) begin
                    n_phase = P_SEMI;
                end else begin
                    n_phase = P_TEXT;
                end
            end
            P_SEMI, P_COL: begin
                if (is_digit) begin
                    n_cnum  = acc_sat;
                    n_phase = P_COL;
                end else if (i_byte == CH_F && r_phase == P_COL) begin
                    n_phase = P_TEXT;
                    if (r_rnum >= 8'(ROWS)) begin
                        // repeated scrolls collapse to one copy with a clamped shift
                        o_cmd.scroll = 1'b1;
                        o_cmd.shift  = (over > 9'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                                                             : over[ROW_W-1:0];
                        n_row = ROW_W'(ROWS - 1);
                    end else begin
                        n_row = r_rnum[ROW_W-1:0];
                    end
                    n_col = (r_cnum > 8'(COLS)) ? COL_W'(COLS - 1) : r_cnum[COL_W-1:0];
                end else begin
                    n_phase = P_TEXT;
                end
            end
            default: begin
                n_phase = P_TEXT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_TEXT;
            r_row   <= '0;
            r_col   <= '0;
            r_pend  <= 1'b0;
            r_rnum  <= '0;
            r_cnum  <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_row   <= n_row;
            r_col   <= n_col;
            r_pend  <= n_pend;
            r_rnum  <= n_rnum;
            r_cnum  <= n_cnum;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/tte_seq.sv =====
// Sequencer around the cell memory: reset clear, scroll copy, cell write, refresh readout.
// Depends on tte_pkg; commands come from tte_byte_dec.
`default_nettype none

module tte_seq
    import tte_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_kind,
    input  wire logic              i_enable,
    input  wire t_cmd              i_cmd,
    output logic                   o_ready,
    output logic                   o_take,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [OFF_W-1:0]       o_out_offset,
    output logic [DATA_W-1:0]      o_out_data,
    output logic                   o_out_last
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_COPY, S_BLANK, S_WRITE,
        S_REF_READ, S_REF_FILL, S_REF_EMIT, S_STROBE1, S_STROBE0
    } t_state;

    logic [7:0]         mem [CELLS];
    logic [7:0]         r_rdata;

    t_state             r_state;
    logic [ADDR_W-1:0]  r_idx;
    logic [ROW_W-1:0]   r_drow;
    logic [DCOL_W-1:0]  r_dcol;
    logic               r_done;
    logic               r_pend;
    logic [ADDR_W-1:0]  r_pend_addr;
    logic [1:0]         r_pend_b;
    logic               r_pend_pad;
    logic [ROW_W-1:0]   r_shift;
    logic               r_has_wr;
    logic [ADDR_W-1:0]  r_wr_addr;
    logic [7:0]         r_wr_data;
    logic [WORD_W-1:0]  r_w;
    logic [1:0]         r_b;
    logic [DATA_W-1:0]  r_word;
    logic               r_out_valid;
    logic [OFF_W-1:0]   r_out_off;
    logic [DATA_W-1:0]  r_out_data;
    logic               r_out_last;

    logic               accept;
    logic               out_slot;
    logic [ROW_W:0]     src_row_x;
    logic [ROW_W-1:0]   src_row;
    logic [IDX_W-1:0]   ref_idx;
    logic               ref_pad;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign o_take    = accept && i_enable && !i_kind;
    assign out_slot  = !r_out_valid || i_out_ready;

    assign src_row_x = {1'b0, r_drow} + {1'b0, r_shift};
    assign src_row   = (src_row_x > (ROW_W + 1)'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                                                           : src_row_x[ROW_W-1:0];
    assign ref_idx   = {r_w, r_b};
    assign ref_pad   = ({1'b0, ref_idx} >= (IDX_W + 1)'(CELLS));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = CH_BLANK;
            end
            S_COPY: begin
                ram_we    = r_pend;
                ram_waddr = r_pend_addr;
                ram_wdata = r_rdata;
                ram_re    = !r_done;
                ram_raddr = cell_addr(src_row, r_dcol);
            end
            S_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(ROW_W'(ROWS - 1), r_dcol);
                ram_wdata = CH_BLANK;
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = r_wr_addr;
                ram_wdata = r_wr_data;
            end
            S_REF_READ: begin
                ram_re    = !ref_pad;
                ram_raddr = ref_idx[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            mem[ram_waddr] <= ram_wdata;
        end
        if (ram_re) begin
            r_rdata <= mem[ram_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_pend && (r_state == S_REF_READ || r_state == S_REF_FILL)) begin
                r_word[8*r_pend_b +: 8] <= r_pend_pad ? 8'h00 : r_rdata;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == ADDR_W'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept && i_enable) begin
                        if (i_kind) begin
                            r_w     <= '0;
                            r_b     <= '0;
                            r_state <= S_REF_READ;
                        end else begin
                            r_shift   <= i_cmd.shift;
                            r_has_wr  <= i_cmd.write;
                            r_wr_addr <= i_cmd.addr;
                            r_wr_data <= i_cmd.data;
                            if (i_cmd.scroll) begin
                                r_drow  <= '0;
                                r_dcol  <= '0;
                                r_done  <= 1'b0;
                                r_state <= S_COPY;
                            end else if (i_cmd.write) begin
                                r_state <= S_WRITE;
                            end
                        end
                    end
                end
                S_COPY: begin
                    if (!r_done) begin
                        r_pend      <= 1'b1;
                        r_pend_addr <= cell_addr(r_drow, r_dcol);
                        if (r_dcol == DCOL_W'(COLS - 1)) begin
                            r_dcol <= '0;
                            if (r_drow == ROW_W'(ROWS - 2)) begin
                                r_done <= 1'b1;
                            end else begin
                                r_drow <= r_drow + 1'b1;
                            end
                        end else begin
                            r_dcol <= r_dcol + 1'b1;
                        end
                    end else begin
                        // last copied cell is written this cycle
                        r_dcol  <= '0;
                        r_state <= S_BLANK;
                    end
                end
                S_BLANK: begin
                    r_dcol <= r_dcol + 1'b1;
                    if (r_dcol == DCOL_W'(COLS - 1)) begin
                        r_state <= r_has_wr ? S_WRITE : S_IDLE;
                    end
                end
                S_WRITE: begin
                    r_state <= S_IDLE;
                end
                S_REF_READ: begin
                    r_pend     <= 1'b1;
                    r_pend_b   <= r_b;
                    r_pend_pad <= ref_pad;
                    r_b        <= r_b + 1'b1;
                    if (r_b == 2'd3) begin
                        r_state <= S_REF_FILL;
                    end
                end
                S_REF_FILL: begin
                    r_state <= S_REF_EMIT;
                end
                S_REF_EMIT: begin
                    if (out_slot) begin
                        r_out_valid <= 1'b1;
                        r_out_off   <= OFF_W'({r_w, 2'b00});
                        r_out_data  <= r_word;
                        r_out_last  <= 1'b0;
                        if (r_w == WORD_W'(WORDS - 1)) begin
                            r_state <= S_STROBE1;
                        end else begin
                            r_w     <= r_w + 1'b1;
                            r_state <= S_REF_READ;
                        end
                    end
                end
                S_STROBE1: begin
                    if (out_slot) begin
                        r_out_valid <= 1'b1;
                        r_out_off   <= STROBE_OFFSET;
                        r_out_data  <= DATA_W'(1);
                        r_out_last  <= 1'b0;
                        r_state     <= S_STROBE0;
                    end
                end
                S_STROBE0: begin
                    if (out_slot) begin
                        r_out_valid <= 1'b1;
                        r_out_off   <= STROBE_OFFSET;
                        r_out_data  <= '0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_offset = r_out_off;
    assign o_out_data   = r_out_data;
    assign o_out_last   = r_out_last;

    // copy pass never lands on the bottom row
    a_copy_dst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY && r_pend) |->
            ({1'b0, r_pend_addr} < (ADDR_W + 1)'((ROWS - 1) * COLS)))
        else $error("scroll copy wrote into the bottom row");

    // source read never collides with the write-back of the previous cell
    a_copy_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COPY && ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("scroll copy read and write hit the same cell");

    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |->
            (r_out_off == STROBE_OFFSET && r_out_data == '0))
        else $error("last flag on a write other than the closing strobe");

    a_ref_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_enable && i_kind) |=> (r_state == S_REF_READ))
        else $error("refresh request did not start the readout");

endmodule

`default_nettype wire

// ===== rtl/core/text_terminal_cell_engine_top.sv =====
// Top level of the text terminal cell engine: stream ports, APB enable register, wiring.
// Depends on tte_pkg, tte_byte_dec and tte_seq.
// Text byte: accepted in IDLE, cell written the next cycle; ready again once that write is done.
// Scroll (newline off the bottom or cursor move below screen): copy pass over rows 0 to
// ROWS-2 plus a blank pass over the bottom row, then the pending cell write; both passes
// share the single cell memory port pair. Refresh: per word 4 reads, a fill and an emit;
// 16 words then 2 strobe writes, each emit waiting while the sink stalls.
// Reset (synchronous, i_rst_n low): cursor 0,0, parser idle, enable 1; then a clearing
// pass writes spaces to all CELLS (64) cells of the cell memory while s_tready stays low.
`default_nettype none

module text_terminal_cell_engine_top
    import tte_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // byte/refresh requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] byte_value
    input  wire logic        s_tuser,    // [0] kind (0 text byte, 1 refresh)

    // display register writes
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,    // [6:0] reg_offset, [38:7] write_data, [39] zero
    output logic             m_tlast,

    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,      // [2] selects the register word
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic               r_enable;
    logic               cfg_wr;
    logic               take;
    t_cmd               cmd;
    logic [OFF_W-1:0]   out_off;
    logic [DATA_W-1:0]  out_data;

    // APB: zero wait states, only the enable register is implemented
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_ENABLE && paddr[1:0] == 2'b00) ? {31'b0, r_enable}
                  : (paddr[2] == REG_ENABLE) ? {31'b0, r_enable} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (cfg_wr && paddr[2] == REG_ENABLE) begin
            r_enable <= pwdata[0];
        end
    end

    // escape parsing and cursor tracking; state advances only on taken text bytes
    tte_byte_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (s_tdata),
        .o_cmd   (cmd)
    );

    // memory sweeps and refresh readout; disabled requests are accepted and dropped
    tte_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_tvalid),
        .i_kind       (s_tuser),
        .i_enable     (r_enable),
        .i_cmd        (cmd),
        .o_ready      (s_tready),
        .o_take       (take),
        .i_out_ready  (m_tready),
        .o_out_valid  (m_tvalid),
        .o_out_offset (out_off),
        .o_out_data   (out_data),
        .o_out_last   (m_tlast)
    );

    assign m_tdata = {1'b0, out_data, out_off};

endmodule

`default_nettype wire
